FILE: rtl/core/psaf_pkg.sv
// Package for the PID set access filter: codes, deny masks, sizes.
// No dependencies.
`default_nettype none
package psaf_pkg;
  localparam int unsigned SetDepthDefault = 64;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_ACCESS = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [1:0] SEL_SELF   = 2'd0;
  localparam logic [1:0] SEL_INJECT = 2'd1;
  localparam logic [1:0] SEL_CRED   = 2'd2;
  localparam logic [1:0] SEL_BANNED = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_NOTFND  = 3'd4;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SELF   = 2'd1;
  localparam logic [1:0] EV_INJECT = 2'd2;

  localparam logic [1:0] KIND_PROC   = 2'd0;
  localparam logic [1:0] KIND_THREAD = 2'd1;

  localparam logic [0:0] CFG_FILTER = 1'd0;
  localparam logic [0:0] CFG_REPORT = 1'd1;

  localparam logic [31:0] DENY_SELF_PROC   = 32'h0000_0A2B;
  localparam logic [31:0] DENY_SELF_THREAD = 32'h0000_0033;
  localparam logic [31:0] DENY_CRED_PROC   = 32'h0000_083A;
  localparam logic [31:0] DENY_INJ_PROC    = 32'h0000_082A;
  localparam logic [31:0] DENY_GUARD_THR   = 32'h0000_0030;
  localparam logic [31:0] SYSTEM_PID       = 32'd4;
endpackage
`default_nettype wire

FILE: rtl/core/pid_set_access_filter_top.sv
// PID set access filter top level: four slot memories scanned one slot a cycle.
// Depends on psaf_pkg.
//
// channel   direction  handshake              payload
// request   in         start_i & !busy_o      operation_i .. desired_access_i
// result    out        done_o (one cycle)     granted_access_o .. status_o
// config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// Reset clears all four sets with a pass over every slot (busy high).
// Every request reads the four memories once per slot, then passes a
// write-back state and a result state. A clear is a write pass over the
// same slots. Results cannot be stalled.
`default_nettype none
module pid_set_access_filter_top import psaf_pkg::*; #(
  parameter int unsigned SET_DEPTH = SetDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [1:0]  set_select_i,
  input  wire logic [31:0] member_pid_i,
  input  wire logic [1:0]  object_kind_i,
  input  wire logic        kernel_handle_i,
  input  wire logic [31:0] actor_pid_i,
  input  wire logic [31:0] target_pid_i,
  input  wire logic [31:0] desired_access_i,
  output logic             done_o,
  output logic [31:0]      granted_access_o,
  output logic             stripped_o,
  output logic [1:0]       event_kind_o,
  output logic             is_member_o,
  output logic [2:0]       status_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [0:0]  cfg_data_i
);
  localparam int unsigned AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam logic [CW-1:0] LAST = CW'(SET_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [31:0] mem_self [SET_DEPTH];
  logic [31:0] mem_inj  [SET_DEPTH];
  logic [31:0] mem_cred [SET_DEPTH];
  logic [31:0] mem_ban  [SET_DEPTH];
  logic [31:0] rd_self, rd_inj, rd_cred, rd_ban;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_addr_q;
  logic          flt_en_q, rep_en_q;

  logic [2:0]  op_q;
  logic [1:0]  sel_q;
  logic [31:0] pid_q, actor_q, target_q, desired_q;
  logic [1:0]  kind_q;
  logic        kern_q;

  // scan flags
  logic pid_in_sel_q, pid_in_self_q, pid_in_cred_q;
  logic tgt_self_q, tgt_cred_q, tgt_inj_q, act_self_q;
  logic free_found_q, ban_found_q;
  logic [AW-1:0] free_idx_q, ban_idx_q;

  logic [31:0] rd_sel;
  always_comb begin
    case (sel_q)
      SEL_SELF:   rd_sel = rd_self;
      SEL_INJECT: rd_sel = rd_inj;
      SEL_CRED:   rd_sel = rd_cred;
      default:    rd_sel = rd_ban;
    endcase
  end

  logic scanning;
  assign scanning = (state_q == S_SCAN);
  logic accept;
  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // write port decision
  logic          wr_en;
  logic [1:0]    wr_sel;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          add_ok;
  logic [2:0]    add_status;

  always_comb begin
    add_status = ST_DONE;
    add_ok = 1'b0;
    if (pid_q == 32'd0) add_status = ST_REFUSED;
    else if (sel_q == SEL_BANNED && (pid_q <= SYSTEM_PID || pid_in_self_q || pid_in_cred_q))
      add_status = ST_REFUSED;
    else if (pid_in_sel_q) add_status = ST_PRESENT;
    else if (!free_found_q) add_status = ST_FULL;
    else add_ok = 1'b1;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_sel = sel_q;
    wr_addr = free_idx_q;
    wr_data = pid_q;
    if (state_q == S_INIT) begin
      wr_en = 1'b1;
      wr_addr = cnt_q[AW-1:0];
      wr_data = '0;
    end else if (scanning && op_q == OP_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = cnt_q[AW-1:0];
      wr_data = '0;
    end else if (state_q == S_WRITE) begin
      if (op_q == OP_ADD) begin
        wr_en = add_ok;
      end else if (op_q == OP_REMOVE) begin
        wr_en = ban_found_q;
        wr_sel = SEL_BANNED;
        wr_addr = ban_idx_q;
        wr_data = '0;
      end
    end
  end

  logic init_all;
  assign init_all = (state_q == S_INIT);

  always_ff @(posedge clk_i) begin
    if (wr_en && (init_all || wr_sel == SEL_SELF))   mem_self[wr_addr] <= wr_data;
    if (wr_en && (init_all || wr_sel == SEL_INJECT)) mem_inj[wr_addr]  <= wr_data;
    if (wr_en && (init_all || wr_sel == SEL_CRED))   mem_cred[wr_addr] <= wr_data;
    if (wr_en && (init_all || wr_sel == SEL_BANNED)) mem_ban[wr_addr]  <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    rd_self <= mem_self[cnt_q[AW-1:0]];
    rd_inj  <= mem_inj[cnt_q[AW-1:0]];
    rd_cred <= mem_cred[cnt_q[AW-1:0]];
    rd_ban  <= mem_ban[cnt_q[AW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:  if (cnt_q == LAST) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_SCAN;
      S_SCAN:  if (rd_vld_q && !(cnt_q < CW'(SET_DEPTH)) ) state_d = S_WRITE;
      S_WRITE: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      flt_en_q <= 1'b0;
      rep_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_index_i == CFG_FILTER) flt_en_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == CFG_REPORT) rep_en_q <= cfg_data_i[0];
      if (state_q == S_INIT) begin
        cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
      end else if (accept) begin
        cnt_q <= '0;
        rd_vld_q <= 1'b0;
      end else if (scanning) begin
        rd_vld_q <= (cnt_q < CW'(SET_DEPTH));
        if (cnt_q < CW'(SET_DEPTH)) cnt_q <= cnt_q + 1'b1;
      end else begin
        rd_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= cnt_q[AW-1:0];
    if (accept) begin
      op_q <= operation_i; sel_q <= set_select_i; pid_q <= member_pid_i;
      kind_q <= object_kind_i; kern_q <= kernel_handle_i; actor_q <= actor_pid_i;
      target_q <= target_pid_i; desired_q <= desired_access_i;
      pid_in_sel_q <= 1'b0; pid_in_self_q <= 1'b0; pid_in_cred_q <= 1'b0;
      tgt_self_q <= 1'b0; tgt_cred_q <= 1'b0; tgt_inj_q <= 1'b0;
      act_self_q <= 1'b0; free_found_q <= 1'b0; ban_found_q <= 1'b0;
      free_idx_q <= '0; ban_idx_q <= '0;
    end else if (scanning && rd_vld_q) begin
      // zero is never a member: every match needs a nonzero key
      if (pid_q != 0 && rd_sel == pid_q) pid_in_sel_q <= 1'b1;
      if (pid_q != 0 && rd_self == pid_q) pid_in_self_q <= 1'b1;
      if (pid_q != 0 && rd_cred == pid_q) pid_in_cred_q <= 1'b1;
      if (target_q != 0 && rd_self == target_q) tgt_self_q <= 1'b1;
      if (target_q != 0 && rd_cred == target_q) tgt_cred_q <= 1'b1;
      if (target_q != 0 && rd_inj == target_q) tgt_inj_q <= 1'b1;
      if (actor_q != 0 && rd_self == actor_q) act_self_q <= 1'b1;
      if (!free_found_q && rd_sel == 32'd0) begin
        free_found_q <= 1'b1; free_idx_q <= rd_addr_q;
      end
      if (!ban_found_q && pid_q != 0 && rd_ban == pid_q) begin
        ban_found_q <= 1'b1; ban_idx_q <= rd_addr_q;
      end
    end
  end

  // result formation
  logic [31:0] deny, res_grant;
  logic        res_strip, res_member;
  logic [1:0]  res_event;
  logic [2:0]  res_status;
  logic        guarded, exempt;
  always_comb begin
    guarded = tgt_self_q || tgt_cred_q || tgt_inj_q;
    exempt = !flt_en_q || kern_q || (kind_q != KIND_PROC && kind_q != KIND_THREAD) ||
             !guarded || actor_q == target_q || actor_q == SYSTEM_PID || act_self_q;
    if (tgt_self_q) deny = (kind_q == KIND_THREAD) ? DENY_SELF_THREAD : DENY_SELF_PROC;
    else if (tgt_cred_q) deny = (kind_q == KIND_THREAD) ? DENY_GUARD_THR : DENY_CRED_PROC;
    else deny = (kind_q == KIND_THREAD) ? DENY_GUARD_THR : DENY_INJ_PROC;
    res_grant = '0; res_strip = 1'b0; res_event = EV_NONE;
    res_member = 1'b0; res_status = ST_DONE;
    case (op_q)
      OP_ADD:    res_status = add_status;
      OP_CLEAR:  res_status = ST_DONE;
      OP_REMOVE: res_status = ban_found_q ? ST_DONE : ST_NOTFND;
      OP_ACCESS: begin
        res_grant = desired_q;
        if (!exempt && (desired_q & deny) != 0) begin
          res_grant = desired_q & ~deny;
          res_strip = 1'b1;
          // self membership outranks credential membership
          if (rep_en_q && tgt_self_q) res_event = EV_SELF;
          else if (rep_en_q && !tgt_cred_q) res_event = EV_INJECT;
        end
      end
      OP_QUERY:  res_member = pid_in_sel_q;
      default:   res_status = ST_REFUSED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= (state_q == S_WRITE);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      granted_access_o <= res_grant; stripped_o <= res_strip;
      event_kind_o <= res_event; is_member_o <= res_member; status_o <= res_status;
    end
  end

  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_WRITE) else $error("result without write-back");
  a_busy_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("idle while result shown");
  a_no_strip_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !stripped_o |-> event_kind_o == EV_NONE) else $error("event without strip");
endmodule
`default_nettype wire

FILE: tb/pid_set_access_filter_top_tb.sv
// Self-checking testbench for the PID set access filter top level.
// Depends on psaf_pkg and pid_set_access_filter_top; runs a directed table, then random requests.
`timescale 1ns / 100ps
module pid_set_access_filter_top_tb;
  import psaf_pkg::*;

  localparam int Depth = 64;
  localparam int NumRandom = 650;
  localparam int CycleLimit = 400000;
  localparam logic [2:0] OP_BAD = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  sel;
    logic [31:0] pid;
    logic [1:0]  kind;
    logic        kern;
    logic [31:0] actor;
    logic [31:0] target;
    logic [31:0] desired;
  } req_t;

  typedef struct packed {
    logic [31:0] granted;
    logic        strip;
    logic [1:0]  ev;
    logic        member;
    logic [2:0]  status;
  } res_t;

  typedef struct {
    req_t req;
    bit   fixed;
    res_t res;
  } row_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic start = 1'b0;
  req_t req_q = '0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = '0, cfg_dat = '0;
  logic busy, done, strip_o, member_o;
  logic [31:0] granted_o;
  logic [1:0] ev_o;
  logic [2:0] status_o;

  pid_set_access_filter_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .operation_i(req_q.op), .set_select_i(req_q.sel), .member_pid_i(req_q.pid),
    .object_kind_i(req_q.kind), .kernel_handle_i(req_q.kern),
    .actor_pid_i(req_q.actor), .target_pid_i(req_q.target),
    .desired_access_i(req_q.desired), .done_o(done),
    .granted_access_o(granted_o), .stripped_o(strip_o), .event_kind_o(ev_o),
    .is_member_o(member_o), .status_o(status_o),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_idx), .cfg_data_i(cfg_dat)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [31:0] pid_sets [4][Depth];
  int banned_cnt;
  bit filter_on, report_on;
  res_t expected_q[$];
  int errors = 0, n_checked = 0, n_strips = 0, cycles = 0;

  function automatic bit holds(int s, logic [31:0] p);
    if (p == 0) return 0;
    for (int i = 0; i < Depth; i++) if (pid_sets[s][i] == p) return 1;
    return 0;
  endfunction

  function automatic logic [2:0] insert_pid(int s, logic [31:0] p);
    if (p == 0) return ST_REFUSED;
    if (holds(s, p)) return ST_PRESENT;
    for (int i = 0; i < Depth; i++)
      if (pid_sets[s][i] == 0) begin
        pid_sets[s][i] = p;
        return ST_DONE;
      end
    return ST_FULL;
  endfunction

  function automatic res_t filter_result(req_t r);
    res_t o;
    bit is_s, is_c, is_i;
    logic [31:0] deny;
    o = '0;
    case (r.op)
      OP_ADD: begin
        if (r.sel == SEL_BANNED) begin
          if (r.pid <= SYSTEM_PID || holds(SEL_SELF, r.pid) || holds(SEL_CRED, r.pid))
            o.status = ST_REFUSED;
          else begin
            o.status = insert_pid(SEL_BANNED, r.pid);
            if (o.status == ST_DONE) banned_cnt++;
          end
        end else o.status = insert_pid(r.sel, r.pid);
      end
      OP_CLEAR: begin
        for (int i = 0; i < Depth; i++) pid_sets[r.sel][i] = 0;
        if (r.sel == SEL_BANNED) banned_cnt = 0;
      end
      OP_REMOVE: begin
        o.status = ST_NOTFND;
        if (r.pid != 0)
          for (int i = 0; i < Depth; i++)
            if (pid_sets[SEL_BANNED][i] == r.pid) begin
              pid_sets[SEL_BANNED][i] = 0;
              if (banned_cnt > 0) banned_cnt--;
              o.status = ST_DONE;
              break;
            end
      end
      OP_ACCESS: begin
        o.granted = r.desired;
        if (filter_on && !r.kern && r.kind <= KIND_THREAD) begin
          is_s = holds(SEL_SELF, r.target);
          is_c = !is_s && holds(SEL_CRED, r.target);
          is_i = !is_s && !is_c && holds(SEL_INJECT, r.target);
          if ((is_s || is_c || is_i) && r.actor != r.target && r.actor != SYSTEM_PID
              && !holds(SEL_SELF, r.actor)) begin
            if (is_s) deny = (r.kind == KIND_THREAD) ? DENY_SELF_THREAD : DENY_SELF_PROC;
            else if (is_c) deny = (r.kind == KIND_THREAD) ? DENY_GUARD_THR : DENY_CRED_PROC;
            else deny = (r.kind == KIND_THREAD) ? DENY_GUARD_THR : DENY_INJ_PROC;
            if ((r.desired & deny) != 0) begin
              o.granted = r.desired & ~deny;
              o.strip = 1'b1;
              if (report_on && !is_c) o.ev = is_s ? EV_SELF : EV_INJECT;
            end
          end
        end
      end
      OP_QUERY: o.member = holds(r.sel, r.pid);
      default: o.status = ST_REFUSED;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    res_t w;
    cycles++;
    if (done) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", 32'd0, 32'd0);
      else begin
        w = expected_q.pop_front();
        n_checked++;
        if (granted_o !== w.granted) report_mismatch("granted", granted_o, w.granted);
        if (strip_o !== w.strip) report_mismatch("stripped", 32'(strip_o), 32'(w.strip));
        if (ev_o !== w.ev) report_mismatch("event", 32'(ev_o), 32'(w.ev));
        if (member_o !== w.member)
          report_mismatch("member", 32'(member_o), 32'(w.member));
        if (status_o !== w.status)
          report_mismatch("status", 32'(status_o), 32'(w.status));
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  // drive at negedge; held until accepted at a posedge with busy low
  task automatic send(req_t r, bit fixed, res_t fres);
    res_t p;
    @(negedge clk);
    req_q <= r;
    start <= 1'b1;
    // busy only moves at the rising edge, so it is stable here
    while (busy) @(negedge clk);
    @(posedge clk);
    p = filter_result(r);
    if (fixed && p !== fres) report_mismatch("table row", 32'(p), 32'(fres));
    expected_q.push_back(p);
    if (p.strip) n_strips++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic write_cfg(bit f, bit rp);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (Depth + 8) @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= CFG_FILTER; cfg_dat <= f;
    @(negedge clk);
    cfg_idx <= CFG_REPORT; cfg_dat <= rp;
    @(negedge clk);
    cfg_we <= 1'b0;
    filter_on = f;
    report_on = rp;
  endtask

  function automatic req_t mk(logic [2:0] op, logic [1:0] sel, logic [31:0] pid,
                              logic [1:0] kind, logic kern, logic [31:0] actor,
                              logic [31:0] target, logic [31:0] desired);
    req_t r;
    r.op = op; r.sel = sel; r.pid = pid; r.kind = kind; r.kern = kern;
    r.actor = actor; r.target = target; r.desired = desired;
    return r;
  endfunction

  function automatic logic [31:0] pick_pid();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 6);
      1: return $urandom;
      default: return $urandom_range(5, 40);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    r = mk(OP_QUERY, 2'($urandom), pick_pid(), 2'($urandom), $urandom_range(0, 7) == 0,
           pick_pid(), pick_pid(), $urandom);
    k = $urandom_range(0, 99);
    if (k < 30) r.op = OP_ADD;
    else if (k < 33) r.op = OP_CLEAR;
    else if (k < 43) r.op = OP_REMOVE;
    else if (k < 83) r.op = OP_ACCESS;
    else if (k < 97) r.op = OP_QUERY;
    else r.op = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 1)) r.desired = $urandom_range(0, 4095);
    return r;
  endfunction

  row_t rows[$];

  task automatic add_row(req_t r, bit fixed = 0, res_t fres = '0);
    row_t t;
    t.req = r; t.fixed = fixed; t.res = fres;
    rows.push_back(t);
  endtask

  initial begin
    for (int s = 0; s < 4; s++) for (int i = 0; i < Depth; i++) pid_sets[s][i] = 0;
    banned_cnt = 0; filter_on = 0; report_on = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed table; fixed rows carry results readable at a glance
    add_row(mk(OP_QUERY, SEL_SELF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1, '0);
    add_row(mk(OP_ACCESS, SEL_SELF, 0, KIND_PROC, 0, 9, 10, 32'hFFFF_FFFF), 1,
            '{32'hFFFF_FFFF, 1'b0, EV_NONE, 1'b0, ST_DONE});
    add_row(mk(OP_ADD, SEL_SELF, 0, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_REFUSED});
    add_row(mk(OP_ADD, SEL_SELF, 32'd100, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_DONE});
    add_row(mk(OP_ADD, SEL_SELF, 32'd100, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_PRESENT});
    add_row(mk(OP_ADD, SEL_CRED, 32'd200, 0, 0, 0, 0, 0));
    add_row(mk(OP_ADD, SEL_INJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    add_row(mk(OP_ADD, SEL_INJECT, 32'd200, 0, 0, 0, 0, 0));
    add_row(mk(OP_ADD, SEL_BANNED, 32'd4, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_REFUSED});
    add_row(mk(OP_ADD, SEL_BANNED, 32'd100, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_REFUSED});
    add_row(mk(OP_ADD, SEL_BANNED, 32'd5, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_DONE});
    add_row(mk(OP_REMOVE, SEL_SELF, 32'd5, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_DONE});
    add_row(mk(OP_REMOVE, SEL_BANNED, 32'd5, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_NOTFND});
    add_row(mk(OP_REMOVE, SEL_BANNED, 0, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_NOTFND});
    add_row(mk(OP_QUERY, SEL_SELF, 0, 0, 0, 0, 0, 0), 1, '0);
    add_row(mk(OP_QUERY, SEL_INJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    add_row(mk(OP_BAD, SEL_SELF, 32'd7, 0, 0, 0, 0, 0), 1, '{0, 0, EV_NONE, 0, ST_REFUSED});
    for (int i = 0; i < rows.size(); i++) send(rows[i].req, rows[i].fixed, rows[i].res);
    rows.delete();

    write_cfg(1, 1);
    add_row(mk(OP_ACCESS, 0, 0, KIND_PROC, 0, 9, 100, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, KIND_THREAD, 0, 9, 100, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, KIND_PROC, 0, 9, 200, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, KIND_THREAD, 0, 9, 32'hFFFF_FFFF, 32'h0000_0030));
    add_row(mk(OP_ACCESS, 0, 0, KIND_PROC, 1, 9, 100, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, 2'd3, 0, 9, 100, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, KIND_PROC, 0, 4, 100, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, KIND_PROC, 0, 100, 200, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, KIND_PROC, 0, 100, 100, 32'hFFFF_FFFF));
    add_row(mk(OP_ACCESS, 0, 0, KIND_PROC, 0, 9, 100, 32'hFFFF_F5D4));
    for (int i = 0; i < rows.size(); i++) send(rows[i].req, 0, '0);
    add_row(mk(OP_CLEAR, SEL_SELF, 0, 0, 0, 0, 0, 0), 1, '0);
    add_row(mk(OP_CLEAR, SEL_BANNED, 0, 0, 0, 0, 0, 0), 1, '0);
    for (int i = rows.size() - 2; i < rows.size(); i++)
      send(rows[i].req, rows[i].fixed, rows[i].res);

    // fill one set past its limit
    for (int i = 0; i < Depth + 1; i++)
      send(mk(OP_ADD, SEL_INJECT, 32'd1000 + i, 0, 0, 0, 0, 0), 0, '0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 160 == 80) write_cfg(1'($urandom), 1'($urandom));
      if (n == 300) write_cfg(0, 0);
      if (n == 400) write_cfg(1, 0);
      if (n == 500) write_cfg(1, 1);
      idle_gap();
      send(rand_req(), 0, '0);
    end

    while (expected_q.size() != 0) @(posedge clk);
    repeat (Depth + 8) @(posedge clk);
    $display("checked %0d results, %0d with stripped access, over several filter settings",
             n_checked, n_strips);
    if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
